// ===== rtl/c2s_pkg.sv =====
// ---------------------------------------------------------------------------
// c2s_pkg
// Shared types, constants and the arctangent table of the Cartesian to
// spherical converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c2s_pkg;

   // guard fraction bits carried under the coordinates
   localparam int FRAC_BITS = 16;
   // wide enough for a 32-bit coordinate with guard bits and two CORDIC gains
   localparam int DATA_W    = 56;
   // signed angle accumulator
   localparam int ANG_W     = 34;
   localparam int TABLE_LEN = 40;

   // 0.60725293500888 in unsigned Q0.32
   localparam logic [31:0]        GAIN_Q32 = 32'h9B74_EDA8;
   localparam logic signed [31:0] LAT_MAX  = 32'sh4000_0000;
   localparam logic signed [31:0] LAT_MIN  = -32'sh4000_0000;

   typedef struct packed {
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic signed [31:0] z_coord;
   } req_payload_type;

   typedef struct packed {
      logic [31:0]        radius;
      logic [31:0]        longitude;
      logic signed [31:0] latitude;
   } rsp_payload_type;

   // side data riding along the first CORDIC pass
   typedef struct packed {
      logic signed [31:0] z_coord;
      logic               half_turn;
      logic               xy_zero;
      logic               all_zero;
   } p1_side_type;

   // side data riding along the first gain stage
   typedef struct packed {
      logic signed [31:0] z_coord;
      logic [31:0]        longitude;
      logic               all_zero;
   } g1_side_type;

   // side data riding along the second CORDIC pass
   typedef struct packed {
      logic [31:0] longitude;
      logic        all_zero;
   } p2_side_type;

   // side data riding along the second gain stage
   typedef struct packed {
      logic [31:0]        longitude;
      logic signed [31:0] latitude;
      logic               all_zero;
   } g2_side_type;

   // atan(2^-i) in units of 2pi/2^32
   function automatic logic [31:0] atan_entry(input int idx);
      logic [31:0] entry;
      case (idx)
         0:  entry = 32'h2000_0000;
         1:  entry = 32'h12E4_051E;
         2:  entry = 32'h09FB_385B;
         3:  entry = 32'h0511_11D4;
         4:  entry = 32'h028B_0D43;
         5:  entry = 32'h0145_D7E1;
         6:  entry = 32'h00A2_F61E;
         7:  entry = 32'h0051_7C55;
         8:  entry = 32'h0028_BE53;
         9:  entry = 32'h0014_5F2F;
         10: entry = 32'h000A_2F98;
         11: entry = 32'h0005_17CC;
         12: entry = 32'h0002_8BE6;
         13: entry = 32'h0001_45F3;
         14: entry = 32'h0000_A2FA;
         15: entry = 32'h0000_517D;
         16: entry = 32'h0000_28BE;
         17: entry = 32'h0000_145F;
         18: entry = 32'h0000_0A30;
         19: entry = 32'h0000_0518;
         20: entry = 32'h0000_028C;
         21: entry = 32'h0000_0146;
         22: entry = 32'h0000_00A3;
         23: entry = 32'h0000_0051;
         24: entry = 32'h0000_0029;
         25: entry = 32'h0000_0014;
         26: entry = 32'h0000_000A;
         27: entry = 32'h0000_0005;
         28: entry = 32'h0000_0003;
         29: entry = 32'h0000_0001;
         30: entry = 32'h0000_0001;
         default: entry = 32'h0000_0000;
      endcase
      return entry;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/c2s_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// c2s_cordic_cell
// One registered CORDIC vectoring micro-rotation with its own beat buffer;
// cells chain into a full vectoring pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c2s_cordic_cell #(
   parameter int STAGE  = 0,
   parameter int SIDE_W = 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              up_valid,
   output logic                                   up_ready,
   input  wire logic signed [c2s_pkg::DATA_W-1:0] up_x,
   input  wire logic signed [c2s_pkg::DATA_W-1:0] up_y,
   input  wire logic signed [c2s_pkg::ANG_W-1:0]  up_ang,
   input  wire logic [SIDE_W-1:0]                 up_side,
   output logic                                   dn_valid,
   input  wire logic                              dn_ready,
   output logic signed [c2s_pkg::DATA_W-1:0]      dn_x,
   output logic signed [c2s_pkg::DATA_W-1:0]      dn_y,
   output logic signed [c2s_pkg::ANG_W-1:0]       dn_ang,
   output logic [SIDE_W-1:0]                      dn_side
);

   localparam int DATA_W = c2s_pkg::DATA_W;
   localparam int ANG_W  = c2s_pkg::ANG_W;
   localparam logic signed [ANG_W-1:0] STEP_ANG = ANG_W'(c2s_pkg::atan_entry(STAGE));

   logic                     valid_ff;
   logic signed [DATA_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [ANG_W-1:0]  ang_ff, ang_in;
   logic [SIDE_W-1:0]        side_ff;
   logic signed [DATA_W-1:0] dx, dy;

   assign dx = up_y >>> STAGE;
   assign dy = up_x >>> STAGE;

   // rotate towards the x axis
   always_comb begin
      if (!up_y[DATA_W-1]) begin
         x_in   = up_x + dx;
         y_in   = up_y - dy;
         ang_in = up_ang + STEP_ANG;
      end else begin
         x_in   = up_x - dx;
         y_in   = up_y + dy;
         ang_in = up_ang - STEP_ANG;
      end
   end

   assign up_ready = ~valid_ff | dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         ang_ff  <= ang_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_ang   = ang_ff;
   assign dn_side  = side_ff;

   // vectoring never drives x negative from a non-negative start
   a_x_nonneg: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !x_ff[DATA_W-1])
      else $error("cordic cell x went negative");

endmodule

`default_nettype wire

// ===== rtl/c2s_gain_stage.sv =====
// ---------------------------------------------------------------------------
// c2s_gain_stage
// Removes the CORDIC gain: (a * gain + 2^31) >> 32, as two partial
// products in one stage and their rounded sum in the next.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c2s_gain_stage #(
   parameter int SIDE_W = 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       up_valid,
   output logic                            up_ready,
   input  wire logic [c2s_pkg::DATA_W-1:0] up_value,
   input  wire logic [SIDE_W-1:0]          up_side,
   output logic                            dn_valid,
   input  wire logic                       dn_ready,
   output logic [c2s_pkg::DATA_W-1:0]      dn_value,
   output logic [SIDE_W-1:0]               dn_side
);

   localparam int DATA_W = c2s_pkg::DATA_W;
   localparam int HI_W   = DATA_W - 32;

   logic              prod_valid_ff, out_valid_ff, prod_ready;
   logic [63:0]       lo_prod_ff, lo_prod_in, lo_round;
   logic [DATA_W-1:0] hi_prod_ff, hi_prod_in;
   logic [SIDE_W-1:0] prod_side_ff, out_side_ff;
   logic [DATA_W-1:0] value_ff, value_in;

   assign lo_prod_in = 64'(up_value[31:0]) * 64'(c2s_pkg::GAIN_Q32);
   assign hi_prod_in = DATA_W'(up_value[DATA_W-1:32]) * DATA_W'(c2s_pkg::GAIN_Q32);

   // low partial product rounded half up before its upper word joins
   assign lo_round = lo_prod_ff + 64'h0000_0000_8000_0000;
   assign value_in = hi_prod_ff + DATA_W'(lo_round[63:32]);

   assign prod_ready = ~out_valid_ff | dn_ready;
   assign up_ready   = ~prod_valid_ff | prod_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (up_ready) begin
            prod_valid_ff <= up_valid;
         end
         if (prod_ready) begin
            out_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         lo_prod_ff   <= lo_prod_in;
         hi_prod_ff   <= hi_prod_in;
         prod_side_ff <= up_side;
      end
      if (prod_valid_ff && prod_ready) begin
         value_ff    <= value_in;
         out_side_ff <= prod_side_ff;
      end
   end

   assign dn_valid = out_valid_ff;
   assign dn_value = value_ff;
   assign dn_side  = out_side_ff;

   // the high partial product is bounded since HI_W bits hold the upper word
   a_hi_fits: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff |-> (hi_prod_ff[DATA_W-1] == 1'b0 || HI_W > DATA_W))
      else $error("gain stage high product overflow");

endmodule

`default_nettype wire

// ===== rtl/cartesian_to_spherical_converter.sv =====
// ---------------------------------------------------------------------------
// cartesian_to_spherical_converter
// Radius, longitude and latitude of a Cartesian vector through two chains
// of CORDIC vectoring cells, each followed by a gain correction stage.
//
//   channel  direction  handshake              beat payload
//   req      in         req_valid / req_ready  x_coord, y_coord, z_coord
//   rsp      out        rsp_valid / rsp_ready  radius, longitude, latitude
//
// One vector is taken every cycle while rsp is not stalled; a vector passes
// through the input stage, CORDIC_STEPS cells, two gain registers,
// CORDIC_STEPS cells, two gain registers and the output register.
// Every cell keeps its beat until the next one can take it, so a stalled
// rsp side fills the bubbles first and only then holds off req.
// Reset clears the valid flags only.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_spherical_converter #(
   parameter int CORDIC_STEPS = 32,
   parameter int COORD_WIDTH  = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire c2s_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output c2s_pkg::rsp_payload_type      rsp_payload
);

   localparam int DATA_W    = c2s_pkg::DATA_W;
   localparam int ANG_W     = c2s_pkg::ANG_W;
   localparam int FRAC_BITS = c2s_pkg::FRAC_BITS;
   localparam int IN_W      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int P1_SIDE_W = $bits(c2s_pkg::p1_side_type);
   localparam int G1_SIDE_W = $bits(c2s_pkg::g1_side_type);
   localparam int P2_SIDE_W = $bits(c2s_pkg::p2_side_type);
   localparam int G2_SIDE_W = $bits(c2s_pkg::g2_side_type);
   localparam logic signed [ANG_W-1:0] ANG_LAT_MAX = ANG_W'(c2s_pkg::LAT_MAX);
   localparam logic signed [ANG_W-1:0] ANG_LAT_MIN = ANG_W'(c2s_pkg::LAT_MIN);

   // input stage
   logic signed [IN_W-1:0]   x_raw, y_raw, z_raw;
   logic signed [DATA_W-1:0] x_ext, y_ext;
   logic signed [DATA_W-1:0] prep_x_in, prep_y_in, prep_x_ff, prep_y_ff;
   c2s_pkg::p1_side_type     prep_side_in, prep_side_ff;
   logic                     prep_valid_ff;

   // first pass chain
   logic                     p1_valid [CORDIC_STEPS+1];
   logic                     p1_ready [CORDIC_STEPS+1];
   logic signed [DATA_W-1:0] p1_x     [CORDIC_STEPS+1];
   logic signed [DATA_W-1:0] p1_y     [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0]  p1_ang   [CORDIC_STEPS+1];
   logic [P1_SIDE_W-1:0]     p1_side  [CORDIC_STEPS+1];

   c2s_pkg::p1_side_type     p1_end_side;
   c2s_pkg::g1_side_type     g1_up_side, g1_dn_side;
   logic [31:0]              lon_end;
   logic [DATA_W-1:0]        g1_up_value, g1_dn_value;
   logic                     g1_valid;
   logic [G1_SIDE_W-1:0]     g1_side_vec;

   // second pass chain
   logic                     p2_valid [CORDIC_STEPS+1];
   logic                     p2_ready [CORDIC_STEPS+1];
   logic signed [DATA_W-1:0] p2_x     [CORDIC_STEPS+1];
   logic signed [DATA_W-1:0] p2_y     [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0]  p2_ang   [CORDIC_STEPS+1];
   logic [P2_SIDE_W-1:0]     p2_side  [CORDIC_STEPS+1];

   c2s_pkg::p2_side_type     p2_end_side;
   c2s_pkg::g2_side_type     g2_up_side, g2_dn_side;
   logic signed [31:0]       lat_end;
   logic [DATA_W-1:0]        g2_up_value, g2_dn_value;
   logic                     g2_valid, g2_ready;
   logic [G2_SIDE_W-1:0]     g2_side_vec;

   // output register
   logic [DATA_W-1:0]        rad_sum;
   logic [DATA_W-FRAC_BITS-1:0] rad_wide;
   c2s_pkg::rsp_payload_type rsp_in, rsp_ff;
   logic                     rsp_valid_ff;

   // ---- input stage: sign extension, guard bits, left half plane turn ----
   assign x_raw = req_payload.x_coord[IN_W-1:0];
   assign y_raw = req_payload.y_coord[IN_W-1:0];
   assign z_raw = req_payload.z_coord[IN_W-1:0];
   assign x_ext = DATA_W'(x_raw) <<< FRAC_BITS;
   assign y_ext = DATA_W'(y_raw) <<< FRAC_BITS;

   always_comb begin
      prep_side_in.z_coord   = 32'(z_raw);
      prep_side_in.half_turn = x_raw[IN_W-1];
      prep_side_in.xy_zero   = (x_raw == '0) && (y_raw == '0);
      prep_side_in.all_zero  = prep_side_in.xy_zero && (z_raw == '0);
      if (x_raw[IN_W-1]) begin
         prep_x_in = -x_ext;
         prep_y_in = -y_ext;
      end else begin
         prep_x_in = x_ext;
         prep_y_in = y_ext;
      end
   end

   assign req_ready = ~prep_valid_ff | p1_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (req_ready) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         prep_x_ff    <= prep_x_in;
         prep_y_ff    <= prep_y_in;
         prep_side_ff <= prep_side_in;
      end
   end

   // ---- first pass: (x, y) to planar radius and longitude ----
   assign p1_valid[0] = prep_valid_ff;
   assign p1_x[0]     = prep_x_ff;
   assign p1_y[0]     = prep_y_ff;
   assign p1_ang[0]   = '0;
   assign p1_side[0]  = prep_side_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pass1
      c2s_cordic_cell #(
         .STAGE  (k),
         .SIDE_W (P1_SIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (p1_valid[k]),
         .up_ready (p1_ready[k]),
         .up_x     (p1_x[k]),
         .up_y     (p1_y[k]),
         .up_ang   (p1_ang[k]),
         .up_side  (p1_side[k]),
         .dn_valid (p1_valid[k+1]),
         .dn_ready (p1_ready[k+1]),
         .dn_x     (p1_x[k+1]),
         .dn_y     (p1_y[k+1]),
         .dn_ang   (p1_ang[k+1]),
         .dn_side  (p1_side[k+1])
      );
   end

   // x and y both zero: longitude and planar radius are forced to zero
   assign p1_end_side = c2s_pkg::p1_side_type'(p1_side[CORDIC_STEPS]);
   assign lon_end     = {p1_end_side.half_turn, 31'd0} + p1_ang[CORDIC_STEPS][31:0];

   always_comb begin
      g1_up_side.z_coord  = p1_end_side.z_coord;
      g1_up_side.all_zero = p1_end_side.all_zero;
      if (p1_end_side.xy_zero) begin
         g1_up_side.longitude = '0;
         g1_up_value          = '0;
      end else begin
         g1_up_side.longitude = lon_end;
         g1_up_value          = DATA_W'(p1_x[CORDIC_STEPS]);
      end
   end

   c2s_gain_stage #(
      .SIDE_W (G1_SIDE_W)
   ) u_gain1 (
      .clock    (clock),
      .reset    (reset),
      .up_valid (p1_valid[CORDIC_STEPS]),
      .up_ready (p1_ready[CORDIC_STEPS]),
      .up_value (g1_up_value),
      .up_side  (g1_up_side),
      .dn_valid (g1_valid),
      .dn_ready (p2_ready[0]),
      .dn_value (g1_dn_value),
      .dn_side  (g1_side_vec)
   );

   assign g1_dn_side = c2s_pkg::g1_side_type'(g1_side_vec);

   // ---- second pass: (planar radius, z) to radius and latitude ----
   assign p2_valid[0]          = g1_valid;
   assign p2_x[0]              = signed'(g1_dn_value);
   assign p2_y[0]              = DATA_W'(g1_dn_side.z_coord) <<< FRAC_BITS;
   assign p2_ang[0]            = '0;
   assign p2_side[0]           = {g1_dn_side.longitude, g1_dn_side.all_zero};

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pass2
      c2s_cordic_cell #(
         .STAGE  (k),
         .SIDE_W (P2_SIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (p2_valid[k]),
         .up_ready (p2_ready[k]),
         .up_x     (p2_x[k]),
         .up_y     (p2_y[k]),
         .up_ang   (p2_ang[k]),
         .up_side  (p2_side[k]),
         .dn_valid (p2_valid[k+1]),
         .dn_ready (p2_ready[k+1]),
         .dn_x     (p2_x[k+1]),
         .dn_y     (p2_y[k+1]),
         .dn_ang   (p2_ang[k+1]),
         .dn_side  (p2_side[k+1])
      );
   end

   assign p2_end_side = c2s_pkg::p2_side_type'(p2_side[CORDIC_STEPS]);

   // latitude overshoot clamps to a quarter turn
   always_comb begin
      if (p2_ang[CORDIC_STEPS] > ANG_LAT_MAX) begin
         lat_end = c2s_pkg::LAT_MAX;
      end else if (p2_ang[CORDIC_STEPS] < ANG_LAT_MIN) begin
         lat_end = c2s_pkg::LAT_MIN;
      end else begin
         lat_end = p2_ang[CORDIC_STEPS][31:0];
      end
   end

   always_comb begin
      g2_up_side.longitude = p2_end_side.longitude;
      g2_up_side.latitude  = lat_end;
      g2_up_side.all_zero  = p2_end_side.all_zero;
      if (p2_x[CORDIC_STEPS][DATA_W-1]) begin
         g2_up_value = '0;
      end else begin
         g2_up_value = DATA_W'(p2_x[CORDIC_STEPS]);
      end
   end

   c2s_gain_stage #(
      .SIDE_W (G2_SIDE_W)
   ) u_gain2 (
      .clock    (clock),
      .reset    (reset),
      .up_valid (p2_valid[CORDIC_STEPS]),
      .up_ready (p2_ready[CORDIC_STEPS]),
      .up_value (g2_up_value),
      .up_side  (g2_up_side),
      .dn_valid (g2_valid),
      .dn_ready (g2_ready),
      .dn_value (g2_dn_value),
      .dn_side  (g2_side_vec)
   );

   assign g2_dn_side = c2s_pkg::g2_side_type'(g2_side_vec);

   // ---- radius rounding and saturation, output register ----
   assign rad_sum  = g2_dn_value + DATA_W'(1 << (FRAC_BITS - 1));
   assign rad_wide = rad_sum[DATA_W-1:FRAC_BITS];

   always_comb begin
      if (g2_dn_side.all_zero) begin
         rsp_in = '0;
      end else begin
         if (|rad_wide[DATA_W-FRAC_BITS-1:32]) begin
            rsp_in.radius = 32'hFFFF_FFFF;
         end else begin
            rsp_in.radius = rad_wide[31:0];
         end
         rsp_in.longitude = g2_dn_side.longitude;
         rsp_in.latitude  = g2_dn_side.latitude;
      end
   end

   assign g2_ready = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (g2_ready) begin
         rsp_valid_ff <= g2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (g2_valid && g2_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_lat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.latitude <= c2s_pkg::LAT_MAX)
                    && (rsp_ff.latitude >= c2s_pkg::LAT_MIN))
      else $error("latitude outside a quarter turn");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(g2_valid))
      else $error("result beat without a gain stage beat");

endmodule

`default_nettype wire

// ===== test/cartesian_to_spherical_converter_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cartesian_to_spherical_converter_tb
// Drives vectors through the converter with bursty input and a stalling
// output side. Every beat out is checked against a bit-true CORDIC
// prediction of radius, longitude and latitude.
// ---------------------------------------------------------------------------

module cartesian_to_spherical_converter_tb;

   localparam int          CORDIC_STEPS = 32;
   localparam int          COORD_WIDTH  = 32;
   localparam int          GUARD_BITS   = 16;
   localparam int          RANDOM_BEATS = 1750;
   localparam int          DRAIN_CYCLES = 2 * CORDIC_STEPS + 6 + 20;
   localparam int          HOLD_CYCLES  = 400;
   localparam logic [63:0] GAIN_Q32     = 64'h0000_0000_9B74_EDA8;
   localparam longint      LAT_LIMIT    = 64'sd1073741824;

   // atan(2^-i) in units of 2pi/2^32
   localparam logic [31:0] ATAN_STEP [0:39] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
      32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
      32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000,
      32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
   };

   typedef enum int {FREE_RUN, COIN_TOSS, PERIODIC, HEAVY_STALL} stall_mode_type;

   typedef struct {
      longint mag;
      longint ang;
   } axis_result_type;

   class spherical_scoreboard;
      c2s_pkg::rsp_payload_type expected_spherical [$];
      int unsigned              mismatches;

      // one vectoring pass: turn (x,y) onto the positive x axis
      function automatic axis_result_type rotate_to_axis(longint x0, longint y0);
         axis_result_type res;
         longint          x, y, dx, dy, step;
         int              i;
         x = x0;
         y = y0;
         res.ang = 0;
         for (i = 0; i < CORDIC_STEPS && i < 40; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            step = longint'(ATAN_STEP[i]);
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               res.ang = res.ang + step;
            end else begin
               x = x - dx;
               y = y + dy;
               res.ang = res.ang - step;
            end
         end
         res.mag = x;
         return res;
      endfunction

      // multiply by the CORDIC gain in Q0.32, round half up
      function automatic longint take_out_gain(longint a);
         logic [63:0] u, hi, lo, p;
         u = a;
         hi = u >> 32;
         lo = u & 64'hFFFF_FFFF;
         p = hi * GAIN_Q32;
         p = p + ((lo * GAIN_Q32 + 64'h8000_0000) >> 32);
         return longint'(p);
      endfunction

      function automatic c2s_pkg::rsp_payload_type spherical_of(
         c2s_pkg::req_payload_type v);
         c2s_pkg::rsp_payload_type r;
         longint                   x, y, z, px, py, lat, rx, r2;
         logic [31:0]              lon, base;
         logic [63:0]              rad;
         axis_result_type          planar, spatial;
         x = longint'(v.x_coord);
         y = longint'(v.y_coord);
         z = longint'(v.z_coord);
         if (x == 0 && y == 0 && z == 0) begin
            r = '0;
            return r;
         end
         px = x * (64'sd1 <<< GUARD_BITS);
         py = y * (64'sd1 <<< GUARD_BITS);
         lon = '0;
         if (x == 0 && y == 0) begin
            px = 0;
         end else begin
            base = '0;
            // left half plane: turn by pi first
            if (px < 0) begin
               px = -px;
               py = -py;
               base = 32'h8000_0000;
            end
            planar = rotate_to_axis(px, py);
            lon = base + planar.ang[31:0];
            px = take_out_gain(planar.mag);
         end
         spatial = rotate_to_axis(px, z * (64'sd1 <<< GUARD_BITS));
         lat = spatial.ang;
         if (lat > LAT_LIMIT) lat = LAT_LIMIT;
         if (lat < -LAT_LIMIT) lat = -LAT_LIMIT;
         rx = (spatial.mag < 0) ? 64'sd0 : spatial.mag;
         r2 = take_out_gain(rx);
         rad = r2 + 64'h8000;
         rad = rad >> GUARD_BITS;
         if (rad > 64'hFFFF_FFFF) rad = 64'hFFFF_FFFF;
         r.radius = rad[31:0];
         r.longitude = lon;
         r.latitude = lat[31:0];
         return r;
      endfunction

      function void note_vector(c2s_pkg::req_payload_type v);
         expected_spherical.push_back(spherical_of(v));
      endfunction

      function void report_mismatch(string what, c2s_pkg::rsp_payload_type want,
                                    c2s_pkg::rsp_payload_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t %s: exp rad=%h lon=%h lat=%h  got rad=%h lon=%h lat=%h",
                     $time, what, want.radius, want.longitude, want.latitude,
                     got.radius, got.longitude, got.latitude);
      endfunction

      function void check_result(c2s_pkg::rsp_payload_type got);
         c2s_pkg::rsp_payload_type want;
         if (expected_spherical.size() == 0) begin
            report_mismatch("unexpected beat", '0, got);
            return;
         end
         want = expected_spherical.pop_front();
         if (want.radius != got.radius || want.longitude != got.longitude ||
             want.latitude != got.latitude)
            report_mismatch("mismatch", want, got);
      endfunction
   endclass

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   c2s_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   c2s_pkg::rsp_payload_type rsp_payload;

   spherical_scoreboard board = new();
   int unsigned         accepted_vectors = 0;

   cartesian_to_spherical_converter #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   // sample both channels on the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         board.note_vector(req_payload);
         accepted_vectors++;
      end
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_payload);
   end

   function automatic c2s_pkg::req_payload_type vec(int x, int y, int z);
      c2s_pkg::req_payload_type v;
      v.x_coord = x;
      v.y_coord = y;
      v.z_coord = z;
      return v;
   endfunction

   function automatic logic signed [31:0] random_coord();
      logic signed [31:0] c;
      case ($urandom_range(0, 7))
         0, 1, 2: c = $urandom;
         3, 4:    c = $signed($urandom) >>> $urandom_range(0, 31);
         5:       c = 0;
         6: begin
            case ($urandom_range(0, 3))
               0:       c = 32'sh7FFF_FFFF;
               1:       c = 32'sh8000_0000;
               2:       c = 1;
               default: c = -1;
            endcase
         end
         default: c = $signed($urandom_range(0, 510)) - 255;
      endcase
      return c;
   endfunction

   task automatic send_vector(input c2s_pkg::req_payload_type v);
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_payload <= {$urandom, $urandom, $urandom};
      end
   endtask

   // output side: stretches of different stall patterns plus one long hold-off
   initial begin : receiver
      stall_mode_type mode;
      int             span;
      int             tick;
      bit             hold_done;
      tick = 0;
      hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && accepted_vectors >= 300) begin
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (mode)
               FREE_RUN:  rsp_ready <= 1'b1;
               COIN_TOSS: rsp_ready <= 1'($urandom_range(0, 1));
               PERIODIC:  rsp_ready <= (tick % 5) < 3;
               default:   rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   initial begin : limit
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      c2s_pkg::req_payload_type directed [$];
      int                       sent, burst;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed.push_back(vec(0, 0, 0));
      directed.push_back(vec(0, 0, 1));
      directed.push_back(vec(0, 0, -1));
      directed.push_back(vec(0, 0, 32'sh7FFF_FFFF));
      directed.push_back(vec(0, 0, 32'sh8000_0000));
      directed.push_back(vec(1, 0, 0));
      directed.push_back(vec(-1, 0, 0));
      directed.push_back(vec(0, 1, 0));
      directed.push_back(vec(0, -1, 0));
      directed.push_back(vec(32'sh7FFF_FFFF, 0, 0));
      directed.push_back(vec(32'sh8000_0000, 0, 0));
      directed.push_back(vec(0, 32'sh7FFF_FFFF, 0));
      directed.push_back(vec(0, 32'sh8000_0000, 0));
      directed.push_back(vec(-1000, 1000, 0));
      directed.push_back(vec(-1000, -1000, 500));
      directed.push_back(vec(1, 1, 1));
      directed.push_back(vec(-1, -1, -1));
      directed.push_back(vec(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      directed.push_back(vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
      directed.push_back(vec(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
      directed.push_back(vec(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
      directed.push_back(vec(1, 0, 32'sh7FFF_FFFF));
      directed.push_back(vec(0, -1, 32'sh8000_0000));
      foreach (directed[i]) begin
         send_vector(directed[i]);
         if (i % 4 == 3) idle_sender($urandom_range(1, 3));
      end

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 48);
         repeat (burst) begin
            send_vector({random_coord(), random_coord(), random_coord()});
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
      end
      idle_sender(1);

      while (board.expected_spherical.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.expected_spherical.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
